// ----- rtl/stbf_pkg.sv -----
package stbf_pkg;

  // field and state widths
  localparam int RATE_W   = 16;
  localparam int FREQ_W   = 16;
  localparam int MS_W     = 16;
  localparam int SAMPLE_W = 14;
  localparam int COUNT_W  = 22;
  localparam int HP_W     = 11;
  localparam int FADE_W   = 8;
  localparam int MAG_W    = 13;

  // shared divider geometry
  localparam int DVD_W     = 32;
  localparam int DVS_W     = 17;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // constants of the tone
  localparam logic [FREQ_W-1:0]  MIN_FREQ   = 16'd20;
  localparam logic [DVS_W-1:0]   MS_PER_S   = 17'd1000;
  localparam logic [DVS_W-1:0]   FADE_DIV   = 17'd200;
  localparam logic [MAG_W-1:0]   AMPLITUDE  = 13'd6000;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'h3FFFFF;
  localparam logic [FADE_W-1:0]  FADE_MAX   = 8'd255;
  localparam logic [RATE_W-1:0]  RATE_RESET = 16'd22050;

  // register indexes
  localparam logic REG_RATE   = 1'b0;
  localparam logic REG_ENABLE = 1'b1;

  // input function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } res_t;

endpackage

// ----- rtl/stbf_div.sv -----
module stbf_div (
  input  logic              clk,
  input  logic              rst,
  input  stbf_pkg::div_req_t req,
  output stbf_pkg::div_rsp_t rsp
);
  import stbf_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dq;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              qbit;
  logic [DVS_W-1:0]  rem_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, dq[DVD_W-1]};
    diff     = trial - {1'b0, dvs};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        dq   <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        dq   <= {dq[DVD_W-2:0], qbit};
        rem  <= rem_next;
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done longer than one cycle");

endmodule

// ----- rtl/stbf_seq.sv -----
module stbf_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [stbf_pkg::FREQ_W-1:0]     tone_freq,
  input  logic [stbf_pkg::MS_W-1:0]       duration_ms,
  input  logic [stbf_pkg::RATE_W-1:0]     rate_hz,
  input  logic                            enable,
  output stbf_pkg::res_t                  res,
  input  logic                            res_ready,
  output stbf_pkg::div_req_t              div_req,
  input  stbf_pkg::div_rsp_t              div_rsp
);
  import stbf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_CNT_W,
    S_HP,
    S_HP_W,
    S_FADE,
    S_FADE_W,
    S_TICK,
    S_TICK_W,
    S_OUT
  } state_t;

  state_t state;

  // burst state
  logic               active;
  logic [COUNT_W-1:0] sample_index;
  logic [COUNT_W-1:0] total_samples;
  logic [HP_W-1:0]    half_period;
  logic [HP_W-1:0]    half_period_count;
  logic               square_phase;
  logic [FADE_W-1:0]  fade_length;

  // working registers
  logic [FREQ_W-1:0]  freq;
  logic [DVD_W-1:0]   prod;
  logic [COUNT_W-1:0] count_tmp;
  logic [HP_W-1:0]    hp_tmp;
  logic [MAG_W-1:0]   mag;

  // fade position of the current sample
  logic [COUNT_W-1:0] from_end;
  logic               in_head;
  logic               in_tail;
  logic [FADE_W-1:0]  fade_pos;
  logic [DVD_W-1:0]   fade_prod;

  always_comb begin
    from_end  = total_samples - COUNT_W'(1) - sample_index;
    in_head   = (sample_index < COUNT_W'(fade_length));
    in_tail   = (from_end < COUNT_W'(fade_length));
    fade_pos  = in_head ? sample_index[FADE_W-1:0] : from_end[FADE_W-1:0];
    fade_prod = DVD_W'(AMPLITUDE) * DVD_W'(fade_pos);
  end

  // sample count, half period and fade limits from the divider results
  logic [DVD_W-1:0]   q;
  logic [COUNT_W-1:0] count_sat;
  logic [HP_W-1:0]    hp_min;
  logic [DVD_W-1:0]   half_count;
  logic [DVD_W-1:0]   fade_lim;
  logic [FADE_W-1:0]  fade_new;

  always_comb begin
    q          = div_rsp.quotient;
    count_sat  = (q > DVD_W'(COUNT_MAX)) ? COUNT_MAX : q[COUNT_W-1:0];
    hp_min     = (q == '0) ? HP_W'(1) : q[HP_W-1:0];
    half_count = DVD_W'(count_tmp >> 1);
    fade_lim   = (q > half_count) ? half_count : q;
    fade_new   = (fade_lim > DVD_W'(FADE_MAX)) ? FADE_MAX : fade_lim[FADE_W-1:0];
  end

  // result word and phase advance
  logic [COUNT_W:0] index_inc;
  logic             is_last;
  logic [HP_W-1:0]  hpc_inc;

  always_comb begin
    index_inc  = {1'b0, sample_index} + 1'b1;
    is_last    = (index_inc >= {1'b0, total_samples});
    hpc_inc    = half_period_count + 1'b1;
    res.valid  = (state == S_OUT);
    res.last   = is_last;
    res.sample = square_phase ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = MS_PER_S;
    case (state)
      S_CNT: begin
        div_req.start = 1'b1;
      end
      S_HP: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(rate_hz);
        div_req.divisor  = {freq, 1'b0};
      end
      S_FADE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DVD_W'(rate_hz);
        div_req.divisor  = FADE_DIV;
      end
      S_TICK: begin
        div_req.start   = 1'b1;
        div_req.divisor = DVS_W'(fade_length);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      active            <= 1'b0;
      sample_index      <= '0;
      total_samples     <= '0;
      half_period       <= HP_W'(1);
      half_period_count <= '0;
      square_phase      <= 1'b0;
      fade_length       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (func == FUNC_START) begin
              if (enable && duration_ms != '0) begin
                freq  <= (tone_freq < MIN_FREQ) ? MIN_FREQ : tone_freq;
                prod  <= DVD_W'(rate_hz) * DVD_W'(duration_ms);
                state <= S_CNT;
              end
            end else if (active) begin
              if (in_head || in_tail) begin
                prod  <= fade_prod;
                state <= S_TICK;
              end else begin
                mag   <= AMPLITUDE;
                state <= S_OUT;
              end
            end
          end
        end
        S_CNT:  state <= S_CNT_W;
        S_CNT_W: begin
          if (div_rsp.done) begin
            count_tmp <= count_sat;
            state     <= (q == '0) ? S_IDLE : S_HP;
          end
        end
        S_HP:   state <= S_HP_W;
        S_HP_W: begin
          if (div_rsp.done) begin
            hp_tmp <= hp_min;
            state  <= S_FADE;
          end
        end
        S_FADE: state <= S_FADE_W;
        S_FADE_W: begin
          if (div_rsp.done) begin
            active            <= 1'b1;
            sample_index      <= '0;
            total_samples     <= count_tmp;
            half_period       <= hp_tmp;
            half_period_count <= '0;
            square_phase      <= 1'b0;
            fade_length       <= fade_new;
            state             <= S_IDLE;
          end
        end
        S_TICK: state <= S_TICK_W;
        S_TICK_W: begin
          if (div_rsp.done) begin
            mag   <= q[MAG_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            if (hpc_inc >= half_period) begin
              half_period_count <= '0;
              square_phase      <= ~square_phase;
            end else begin
              half_period_count <= hpc_inc;
            end
            if (is_last) begin
              active <= 1'b0;
            end else begin
              sample_index <= index_inc[COUNT_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_index_in_burst: assert property (@(posedge clk) disable iff (rst)
    active |-> sample_index < total_samples)
    else $error("sample index past end of burst");
  a_fade_fits: assert property (@(posedge clk) disable iff (rst)
    active |-> COUNT_W'(fade_length) <= (total_samples >> 1))
    else $error("fade longer than half the burst");
  a_half_period: assert property (@(posedge clk) disable iff (rst)
    half_period != '0 && half_period_count < half_period)
    else $error("half period counter out of range");
  a_tick_needs_burst: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> active)
    else $error("sample produced with no active burst");

endmodule

// ----- rtl/square_tone_burst_with_fades_top.sv -----
// a start holds the block for up to three 32-step divides on the shared divider
// a tick inside a fade gives its word after one divide, a tick outside a fade without a divide,
//   a start or idle tick gives no word
// one item at a time: the next is taken when the sequencer is back in idle
// reset: synchronous, clears the burst, rate register to 22050, enable to 0
module square_tone_burst_with_fades_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [stbf_pkg::FREQ_W-1:0]       tone_freq,
  input  logic [stbf_pkg::MS_W-1:0]         duration_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [stbf_pkg::SAMPLE_W-1:0] sample,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [stbf_pkg::RATE_W-1:0]       cfg_data
);
  import stbf_pkg::*;

  logic [RATE_W-1:0] rate_hz;
  logic              enable;
  res_t              res;
  logic              res_ready;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_hz <= RATE_RESET;
      enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RATE:   rate_hz <= cfg_data;
        REG_ENABLE: enable  <= cfg_data[0];
        default:    enable  <= enable;
      endcase
    end
  end

  // output word register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
      sample    <= res.sample;
      last      <= res.last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  stbf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .tone_freq   (tone_freq),
    .duration_ms (duration_ms),
    .rate_hz     (rate_hz),
    .enable      (enable),
    .res         (res),
    .res_ready   (res_ready),
    .div_req     (div_req),
    .div_rsp     (div_rsp)
  );

  stbf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// ----- tb/tone_burst_checker.sv -----
module tone_burst_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 func,
  input  logic [stbf_pkg::FREQ_W-1:0]          tone_freq,
  input  logic [stbf_pkg::MS_W-1:0]            duration_ms,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [stbf_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [stbf_pkg::RATE_W-1:0]          cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  import stbf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_word_t;

  // register copies
  logic [RATE_W-1:0]  rate_q;
  logic               enabled;

  // burst state as the block should hold it
  logic               burst_on;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] total;
  logic [HP_W-1:0]    hp;
  logic [HP_W-1:0]    hp_cnt;
  logic               phase;
  logic [FADE_W-1:0]  fade;

  tone_word_t expected_words[$];
  int mismatches = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // start word: sample count, half period and fade from the current rate
  function automatic void arm_burst(input logic [FREQ_W-1:0] freq, input logic [MS_W-1:0] ms);
    longint unsigned f;
    longint unsigned cnt;
    longint unsigned half;
    longint unsigned fl;
    if (!enabled || ms == 0) return;
    f = (freq < MIN_FREQ) ? MIN_FREQ : freq;
    cnt = (longint'(rate_q) * longint'(ms)) / MS_PER_S;
    if (cnt == 0) return;
    if (cnt > COUNT_MAX) cnt = COUNT_MAX;
    half = rate_q / (2 * f);
    if (half < 1) half = 1;
    fl = rate_q / FADE_DIV;
    if (fl > cnt / 2) fl = cnt / 2;
    if (fl > FADE_MAX) fl = FADE_MAX;
    burst_on = 1'b1;
    idx      = '0;
    total    = COUNT_W'(cnt);
    hp       = HP_W'(half);
    hp_cnt   = '0;
    phase    = 1'b0;
    fade     = FADE_W'(fl);
  endfunction

  // tick word: one sample of the running burst, none when idle
  function automatic bit next_sample(output tone_word_t w);
    int unsigned mag;
    int unsigned dist_end;
    int          level;
    bit          at_end;
    w = '0;
    if (!burst_on) return 0;
    mag = AMPLITUDE;
    dist_end = int'(total) - 1 - int'(idx);
    if (idx < fade)
      mag = (int'(AMPLITUDE) * int'(idx)) / int'(fade);
    else if (dist_end < fade)
      mag = (int'(AMPLITUDE) * dist_end) / int'(fade);
    level = phase ? int'(mag) : -int'(mag);
    at_end = (int'(idx) + 1 >= int'(total));
    w.sample = SAMPLE_W'(level);
    w.last = at_end;
    hp_cnt++;
    if (hp_cnt >= hp) begin
      hp_cnt = '0;
      phase = ~phase;
    end
    if (at_end) burst_on = 1'b0;
    else idx++;
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    tone_word_t want;
    if (rst) begin
      rate_q   = RATE_RESET;
      enabled  = 1'b0;
      burst_on = 1'b0;
      idx      = '0;
      total    = '0;
      hp       = HP_W'(1);
      hp_cnt   = '0;
      phase    = 1'b0;
      fade     = '0;
      expected_words.delete();
      pending <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RATE) rate_q = cfg_data;
        else if (cfg_index == REG_ENABLE) enabled = cfg_data[0];
      end
      // compare a delivered word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word: sample %0d last %0b", sample, last));
        end else begin
          want = expected_words.pop_front();
          if (sample !== want.sample)
            report($sformatf("sample: expected %0d got %0d", $signed(want.sample), sample));
          if (last !== want.last)
            report($sformatf("last: expected %0b got %0b", want.last, last));
        end
      end
      // predict from an accepted input word
      if (in_valid && in_ready) begin
        if (func == FUNC_START) arm_burst(tone_freq, duration_ms);
        else if (next_sample(want)) expected_words.push_back(want);
      end
      pending <= expected_words.size();
    end
    fail_count <= mismatches;
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import stbf_pkg::*;

  localparam int HOLD = 150;
  localparam int LIMIT = 1_000_000;
  localparam int RANDOM_WORDS = 850;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       func = FUNC_TICK;
  logic [FREQ_W-1:0]          tone_freq = '0;
  logic [MS_W-1:0]            duration_ms = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = REG_RATE;
  logic [RATE_W-1:0]          cfg_data = '0;

  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                words_sent = 0;
  logic              calm = 1'b0;
  logic [RATE_W-1:0] cur_rate = RATE_RESET;

  square_tone_burst_with_fades_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .tone_freq(tone_freq), .duration_ms(duration_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample(sample), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tone_burst_checker tone_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .tone_freq(tone_freq), .duration_ms(duration_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample(sample), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random except in the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 35);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one input word, with a random gap before it; valid is left high on return
  task automatic send_word(input logic f, input logic [FREQ_W-1:0] fq,
                           input logic [MS_W-1:0] ms);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(0, 99) < 35) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    tone_freq   <= fq;
    duration_ms <= ms;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // ticks carry random payload that the block must ignore
  task automatic send_ticks(input int n);
    repeat (n) send_word(FUNC_TICK, 16'($urandom), 16'($urandom));
  endtask

  // hold off until every predicted word is out and the block has settled
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (HOLD) @(posedge clk);
  endtask

  // both registers, back to back
  task automatic set_tone_regs(input logic [RATE_W-1:0] rate, input logic en);
    cur_rate = rate;
    cfg_valid <= 1'b1;
    cfg_index <= REG_RATE;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_ENABLE;
    cfg_data  <= {{(RATE_W-1){1'b0}}, en};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int                r;
    int                span;
    int                est;
    int                base;
    int                phase_end;
    logic [FREQ_W-1:0] fq;
    logic [MS_W-1:0]   ms;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // disabled after reset: start ignored, tick while idle
    send_word(FUNC_START, 16'd1000, 16'd5);
    send_ticks(1);
    wait_quiet();

    // one-millisecond burst at rate 8000, frequency below the clamp, one tick past the end
    set_tone_regs(16'd8000, 1'b1);
    send_word(FUNC_START, 16'd0, 16'd1);
    send_ticks(9);
    // zero duration ignored
    send_word(FUNC_START, 16'd3000, 16'd0);
    // longest burst at top frequency, cut short by a restart
    send_word(FUNC_START, 16'hFFFF, 16'hFFFF);
    send_ticks(3);
    send_word(FUNC_START, 16'd20, 16'd1);
    send_ticks(2);
    wait_quiet();

    // rate above range: sample count and fade both saturate
    set_tone_regs(16'hFFFF, 1'b1);
    send_word(FUNC_START, 16'd100, 16'hFFFF);
    send_ticks(2);
    wait_quiet();

    // zero sample count leaves the running burst alone; one-sample burst with no fade
    set_tone_regs(16'd1, 1'b1);
    send_word(FUNC_START, 16'd20, 16'd999);
    send_ticks(1);
    send_word(FUNC_START, 16'd19, 16'd1000);
    send_ticks(2);
    wait_quiet();

    // rate 48000 while disabled, then enabled again
    set_tone_regs(16'd48000, 1'b0);
    send_word(FUNC_START, 16'd440, 16'd1);
    send_ticks(1);
    wait_quiet();
    set_tone_regs(16'd48000, 1'b1);

    // random phases, each with its own rate and enable
    base = words_sent;
    while (words_sent < base + RANDOM_WORDS) begin
      wait_quiet();
      case ($urandom_range(0, 7))
        0:       cur_rate = 16'd8000;
        1:       cur_rate = 16'd48000;
        2:       cur_rate = 16'd22050;
        3:       cur_rate = 16'd44100;
        4:       cur_rate = 16'hFFFF;
        5:       cur_rate = 16'($urandom_range(1, 400));
        default: cur_rate = 16'($urandom_range(8000, 48000));
      endcase
      set_tone_regs(cur_rate, $urandom_range(0, 9) != 0);
      phase_end = words_sent + $urandom_range(60, 140);
      while (words_sent < phase_end) begin
        calm <= (words_sent - base >= 300) && (words_sent - base < 450);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // well-formed burst of a few dozen samples, mostly played to its end
          case ($urandom_range(0, 3))
            0:       fq = 16'($urandom_range(0, 19));
            1:       fq = 16'($urandom_range(20, 400));
            2:       fq = 16'($urandom_range(400, 5000));
            default: fq = 16'($urandom);
          endcase
          span = (cur_rate == 0) ? 1 : 60000 / cur_rate;
          if (span < 1) span = 1;
          ms = 16'($urandom_range(1, span));
          est = (int'(cur_rate) * int'(ms)) / 1000;
          send_word(FUNC_START, fq, ms);
          if ($urandom_range(0, 3) != 0) send_ticks(est + $urandom_range(0, 2));
          else send_ticks($urandom_range(0, est));
        end else if (r < 80) begin
          // fully random start, usually a long burst that a later start replaces
          send_word(FUNC_START, 16'($urandom), 16'($urandom));
          send_ticks($urandom_range(0, 4));
        end else if (r < 92) begin
          if ($urandom_range(0, 1) != 0) send_word(FUNC_START, 16'($urandom), '0);
          else send_ticks($urandom_range(1, 3));
        end else begin
          wait_quiet();
        end
      end
    end
    calm <= 1'b0;

    wait_quiet();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
